FILE: sv/lpe_pkg.sv
package lpe_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int SAMPLE_W    = 12;
  localparam int ERR_W       = 13;
  localparam int LOST_W      = 16;
  localparam int SUM_W       = 6;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = ERR_W + RECIP_W;

  // weight of pattern bit b; bit 7 is sensor 0
  localparam logic signed [SUM_W-1:0] BIT_WEIGHT [NUM_SENSORS] =
    '{-6'sd12, -6'sd8, -6'sd4, -6'sd1, 6'sd1, 6'sd4, 6'sd8, 6'sd12};

  localparam logic [SAMPLE_W-1:0] THR_RESET [NUM_SENSORS] =
    '{12'd900, 12'd900, 12'd1100, 12'd700, 12'd1100, 12'd1200, 12'd2000, 12'd2000};

  // ceil(2^19 / c) for c = 1..8
  localparam logic [RECIP_W-1:0] RECIP [NUM_SENSORS] =
    '{20'd524288, 20'd262144, 20'd174763, 20'd131072,
      20'd104858, 20'd87382, 20'd74899, 20'd65536};

  localparam logic [NUM_SENSORS-1:0] PAT_F0 = 8'hF0;
  localparam logic [NUM_SENSORS-1:0] PAT_F8 = 8'hF8;
  localparam logic [NUM_SENSORS-1:0] PAT_FC = 8'hFC;
  localparam logic [NUM_SENSORS-1:0] PAT_0F = 8'h0F;
  localparam logic [NUM_SENSORS-1:0] PAT_1F = 8'h1F;
  localparam logic [NUM_SENSORS-1:0] PAT_3F = 8'h3F;

  typedef enum logic [1:0] {
    CORNER_NONE  = 2'd0,
    CORNER_LEFT  = 2'd1,
    CORNER_RIGHT = 2'd2
  } corner_t;

  typedef struct packed {
    logic                    valid;
    logic [NUM_SENSORS-1:0]  pat;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } merge_t;

  typedef struct packed {
    logic                   valid;
    logic [NUM_SENSORS-1:0] pat;
    logic                   neg;
    logic                   none;
    logic [PROD_W-1:0]      prod;
  } scale_t;

  function automatic corner_t corner_of(input logic [NUM_SENSORS-1:0] pat);
    corner_t k;
    case (pat)
      PAT_F0, PAT_F8, PAT_FC: k = CORNER_LEFT;
      PAT_0F, PAT_1F, PAT_3F: k = CORNER_RIGHT;
      default:                k = CORNER_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/lpe_lane.sv
module lpe_lane (
  input  logic [lpe_pkg::SAMPLE_W-1:0] sample,
  input  logic [lpe_pkg::SAMPLE_W-1:0] threshold,
  output logic                         hit
);
  import lpe_pkg::*;

  assign hit = (sample >= threshold);

endmodule

FILE: sv/lpe_merge.sv
module lpe_merge (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            valid,
  input  logic [lpe_pkg::NUM_SENSORS-1:0] pat,
  output lpe_pkg::merge_t                 mrg
);
  import lpe_pkg::*;

  merge_t mrg_r;
  merge_t mrg_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] sum_v;
    logic [CNT_W-1:0]        cnt_v;
    sum_v = '0;
    cnt_v = '0;
    for (int b = 0; b < NUM_SENSORS; b++) begin
      if (pat[b]) begin
        sum_v = sum_v + BIT_WEIGHT[b];
        cnt_v = cnt_v + CNT_W'(1);
      end
    end
    mrg_nxt.valid = valid;
    mrg_nxt.pat   = pat;
    mrg_nxt.sum   = sum_v;
    mrg_nxt.cnt   = cnt_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mrg_r <= '0;
    end else begin
      mrg_r <= mrg_nxt;
    end
  end

  assign mrg = mrg_r;

endmodule

FILE: sv/lpe_scale.sv
module lpe_scale (
  input  logic            clk,
  input  logic            rst_n,
  input  lpe_pkg::merge_t mrg,
  input  logic            take,
  output lpe_pkg::scale_t scl
);
  import lpe_pkg::*;

  scale_t                  scl_r;
  scale_t                  scl_nxt;
  logic [SUM_W-1:0]        mag_wide;
  logic [ERR_W-1:0]        dividend;
  logic [CNT_W-1:0]        cnt_m1;
  logic [2:0]              recip_idx;

  // |sum| * 256 / cnt as a multiply by ceil(2^19 / cnt), exact for this range
  always_comb begin
    mag_wide  = mrg.sum[SUM_W-1] ? SUM_W'(-mrg.sum) : SUM_W'(mrg.sum);
    dividend  = {mag_wide[SUM_W-2:0], 8'b0};
    cnt_m1    = mrg.cnt - CNT_W'(1);
    recip_idx = cnt_m1[2:0];
    scl_nxt       = scl_r;
    if (mrg.valid) begin
      scl_nxt.valid = 1'b1;
      scl_nxt.pat   = mrg.pat;
      scl_nxt.neg   = mrg.sum[SUM_W-1];
      scl_nxt.none  = (mrg.cnt == '0);
      scl_nxt.prod  = PROD_W'(dividend) * PROD_W'(RECIP[recip_idx]);
    end else if (take) begin
      scl_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_r <= '0;
    end else begin
      scl_r <= scl_nxt;
    end
  end

  assign scl = scl_r;

endmodule

FILE: sv/line_position_estimator.sv
// Line position estimator. Each item carries eight 12-bit sensor samples; each
// is compared with its own threshold register (active at or above it) and the
// active sensors give a weighted mean position in units of 1/256, sensor 0
// weighing +12 and sensor 7 weighing -12, truncated toward zero. When no sensor
// is active the last error is repeated, line_lost is set and a saturating lost
// counter rises. The block holds one item at a time: in_tready falls when an item
// is accepted and rises again in the same cycle that its result appears on
// out_tvalid, so the next item is accepted only once the result has entered the
// output register. The path runs through the lane compare, the weight adder tree
// and the reciprocal multiplier, each behind its own register; the output register
// lets the next item enter while a result waits to be taken. Thresholds are
// written through the APB port at byte address 4*i and reset to 900, 900, 1100,
// 700, 1100, 1200, 2000, 2000.
module line_position_estimator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // sample_s0 .. sample_s7, 12 bits each
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pattern[7:0], position_error[20:8], lost_total[36:21]
  output logic [2:0]  out_tuser,  // line_lost[0], corner_kind[2:1]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lpe_pkg::*;

  logic [SAMPLE_W-1:0]    thr_r [NUM_SENSORS];
  logic [2:0]             cfg_idx;
  logic                   cfg_wr;

  logic                   in_acc;
  logic                   inflight_r;
  logic                   v1_r;
  logic [NUM_SENSORS-1:0] pat1_r;
  logic [NUM_SENSORS-1:0] hits;
  logic [NUM_SENSORS-1:0] pat_in;

  merge_t                 mrg;
  scale_t                 scl;
  logic                   load;

  logic [ERR_W-1:0]       quot;
  logic signed [ERR_W-1:0] err_calc;
  logic signed [ERR_W-1:0] held_error_r;
  logic signed [ERR_W-1:0] held_error_nxt;
  logic [LOST_W-1:0]      lost_cnt_r;
  logic [LOST_W-1:0]      lost_cnt_nxt;

  logic                   out_valid_r;
  logic [NUM_SENSORS-1:0] out_pat_r;
  logic signed [ERR_W-1:0] out_err_r;
  logic                   out_lost_r;
  corner_t                out_corner_r;
  logic [LOST_W-1:0]      out_total_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = {{(32-SAMPLE_W){1'b0}}, thr_r[cfg_idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        thr_r[i] <= THR_RESET[i];
      end
    end else if (cfg_wr) begin
      thr_r[cfg_idx] <= cfg_pwdata[SAMPLE_W-1:0];
    end
  end

  genvar s;
  generate
    for (s = 0; s < NUM_SENSORS; s++) begin : g_lane
      lpe_lane u_lane (
        .sample    (in_tdata[s*SAMPLE_W +: SAMPLE_W]),
        .threshold (thr_r[s]),
        .hit       (hits[s])
      );
      assign pat_in[NUM_SENSORS-1-s] = hits[s];
    end
  endgenerate

  assign in_tready = !inflight_r;
  assign in_acc    = in_tvalid & in_tready;
  assign load      = scl.valid & (!out_valid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
      v1_r       <= 1'b0;
    end else begin
      v1_r <= in_acc;
      if (in_acc) begin
        inflight_r <= 1'b1;
      end else if (load) begin
        inflight_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pat1_r <= pat_in;
    end
  end

  lpe_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .valid (v1_r),
    .pat   (pat1_r),
    .mrg   (mrg)
  );

  lpe_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .mrg   (mrg),
    .take  (load),
    .scl   (scl)
  );

  always_comb begin
    quot           = scl.prod[RECIP_SHIFT +: ERR_W];
    err_calc       = scl.neg ? ERR_W'(-quot) : ERR_W'(quot);
    held_error_nxt = held_error_r;
    lost_cnt_nxt   = lost_cnt_r;
    if (load) begin
      if (scl.none) begin
        if (lost_cnt_r != '1) begin
          lost_cnt_nxt = lost_cnt_r + LOST_W'(1);
        end
      end else begin
        held_error_nxt = err_calc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_error_r <= '0;
      lost_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_error_r <= held_error_nxt;
      lost_cnt_r   <= lost_cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pat_r    <= scl.pat;
      out_err_r    <= held_error_nxt;
      out_lost_r   <= scl.none;
      out_corner_r <= corner_of(scl.pat);
      out_total_r  <= lost_cnt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_total_r, out_err_r, out_pat_r};
  assign out_tuser  = {out_corner_r, out_lost_r};

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({v1_r, mrg.valid, scl.valid}))
    else $error("more than one item inside the datapath");

  a_lost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> lost_cnt_r >= $past(lost_cnt_r))
    else $error("lost counter decreased");

  a_lost_holds_error: assert property (@(posedge clk) disable iff (!rst_n)
    load && scl.none |=> out_err_r == $past(held_error_r) && out_tuser[0])
    else $error("lost item did not repeat held error");
`endif

endmodule

FILE: bench/line_position_estimator_tb.sv
`timescale 1ns / 100ps

module line_position_estimator_tb;
  import lpe_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int LANE_WEIGHT [NUM_SENSORS] = '{-12, -8, -4, -1, 1, 4, 8, 12};
  localparam logic [NUM_SENSORS-1:0] CORNER_PATTERNS [6] =
    '{PAT_F0, PAT_F8, PAT_FC, PAT_0F, PAT_1F, PAT_3F};

  typedef logic [NUM_SENSORS-1:0][SAMPLE_W-1:0] reading_t;

  typedef struct packed {
    logic [NUM_SENSORS-1:0] pattern;
    logic signed [ERR_W-1:0] error;
    logic lost;
    corner_t corner;
    logic [LOST_W-1:0] lost_total;
  } estimate_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  reading_t  pending_readings [$];
  estimate_t expected_estimates [$];

  logic [SAMPLE_W-1:0]     thr_shadow [NUM_SENSORS];
  logic signed [ERR_W-1:0] held_error;
  logic [LOST_W-1:0]       lost_tally;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int idle_cycles;

  line_position_estimator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic estimate_t estimate_line(input logic [95:0] data);
    reading_t  smp;
    estimate_t est;
    int        sum;
    int        cnt;
    smp = data;
    sum = 0;
    cnt = 0;
    est.pattern = '0;
    for (int s = 0; s < NUM_SENSORS; s++)
      if (smp[s] >= thr_shadow[s]) est.pattern[NUM_SENSORS-1-s] = 1'b1;
    for (int b = 0; b < NUM_SENSORS; b++)
      if (est.pattern[b]) begin
        sum += LANE_WEIGHT[b];
        cnt++;
      end
    if (cnt == 0) begin
      est.lost = 1'b1;
      if (lost_tally != '1) lost_tally++;
    end else begin
      est.lost = 1'b0;
      held_error = ERR_W'((sum * 256) / cnt);
    end
    est.error = held_error;
    est.lost_total = lost_tally;
    case (est.pattern)
      PAT_F0, PAT_F8, PAT_FC: est.corner = CORNER_LEFT;
      PAT_0F, PAT_1F, PAT_3F: est.corner = CORNER_RIGHT;
      default:                est.corner = CORNER_NONE;
    endcase
    return est;
  endfunction

  // mode 0: anywhere on the right side of the threshold, 1: right at it, 2: within a few counts
  function automatic reading_t shape_reading(input logic [NUM_SENSORS-1:0] pat, input int mode);
    reading_t v;
    int       t;
    int       off;
    for (int s = 0; s < NUM_SENSORS; s++) begin
      t = thr_shadow[s];
      off = (mode == 1) ? 0 : $urandom_range(3);
      if (pat[NUM_SENSORS-1-s])
        v[s] = SAMPLE_W'((mode == 0) ? $urandom_range(4095, t) :
                         ((t + off > 4095) ? 4095 : t + off));
      else if (t == 0)
        v[s] = '0;
      else
        v[s] = SAMPLE_W'((mode == 0) ? $urandom_range(t - 1, 0) :
                         ((t - 1 - off < 0) ? 0 : t - 1 - off));
    end
    return v;
  endfunction

  function automatic reading_t random_reading();
    reading_t               v;
    logic [NUM_SENSORS-1:0] pat;
    if ($urandom_range(99) < 35) begin
      for (int s = 0; s < NUM_SENSORS; s++) v[s] = SAMPLE_W'($urandom_range(4095));
    end else begin
      case ($urandom_range(7))
        0:       pat = '0;
        1:       pat = CORNER_PATTERNS[$urandom_range(5)];
        default: pat = NUM_SENSORS'($urandom_range(255));
      endcase
      v = shape_reading(pat, $urandom_range(2));
    end
    return v;
  endfunction

  task automatic write_threshold(input int idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    thr_shadow[idx] = value[SAMPLE_W-1:0];
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_readings.size() != 0 || in_tvalid || expected_estimates.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_readings.push_back(random_reading());
  endtask

  always @(posedge clk) begin
    logic hold;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      hold = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) expected_estimates.push_back(estimate_line(in_tdata));
      if (!hold) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_readings.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    estimate_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: unexpected item, got tdata %h tuser %h", $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_estimates.pop_front();
        if (out_tdata[7:0] !== want.pattern) begin
          $display("%0t: pattern expected %h got %h", $time, want.pattern, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[20:8] !== want.error) begin
          $display("%0t: position_error expected %0d got %0d", $time, want.error,
                   $signed(out_tdata[20:8]));
          mismatches++;
        end
        if (out_tuser[0] !== want.lost) begin
          $display("%0t: line_lost expected %b got %b", $time, want.lost, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[2:1] !== want.corner) begin
          $display("%0t: corner_kind expected %0d got %0d", $time, want.corner, out_tuser[2:1]);
          mismatches++;
        end
        if (out_tdata[36:21] !== want.lost_total) begin
          $display("%0t: lost_total expected %0d got %0d", $time, want.lost_total,
                   out_tdata[36:21]);
          mismatches++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("line_position_estimator_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    held_error = '0;
    lost_tally = '0;
    send_idle_pct = 10;
    recv_idle_pct = 74;
    for (int s = 0; s < NUM_SENSORS; s++) thr_shadow[s] = THR_RESET[s];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset thresholds, boundaries, corners, lost line
    pending_readings.push_back('0);
    pending_readings.push_back('1);
    for (int s = 0; s < NUM_SENSORS; s++)
      pending_readings.push_back(shape_reading(8'h80 >> s, 1));
    pending_readings.push_back(shape_reading(8'h00, 1));
    foreach (CORNER_PATTERNS[k]) pending_readings.push_back(shape_reading(CORNER_PATTERNS[k], 2));
    pending_readings.push_back(shape_reading(8'hAA, 0));
    pending_readings.push_back(shape_reading(8'h55, 0));
    pending_readings.push_back(shape_reading(8'h83, 1));
    pending_readings.push_back(shape_reading(8'hC1, 1));
    pending_readings.push_back(shape_reading(8'h00, 0));
    pending_readings.push_back(shape_reading(8'h07, 2));
    queue_random(240);
    wait_drained();

    for (int s = 0; s < NUM_SENSORS; s++) write_threshold(s, $urandom());
    send_idle_pct = 74;
    recv_idle_pct = 10;
    queue_random(240);
    wait_drained();

    for (int s = 0; s < NUM_SENSORS; s++)
      write_threshold(s, (s % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF);
    queue_random(40);
    wait_drained();
    for (int s = 0; s < NUM_SENSORS; s++) write_threshold(s, 32'h0000_0FFF);
    queue_random(20);
    pending_readings.push_back('1);
    wait_drained();
    for (int s = 0; s < NUM_SENSORS; s++) write_threshold(s, 32'hFFFF_F000);
    queue_random(20);
    pending_readings.push_back('0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int s = 0; s < NUM_SENSORS; s++)
      write_threshold(s, {20'($urandom_range(32'h000F_FFFF)), 12'($urandom_range(4095, 1))});
    queue_random(150);
    queue_random(10);
    pending_readings.push_back(shape_reading(8'h00, 0));
    wait_drained();

    if (mismatches == 0 && expected_estimates.size() == 0) begin
      $display("line_position_estimator_tb passed");
    end else begin
      $display("line_position_estimator_tb failed");
    end
    $finish;
  end

endmodule
